>>> src/active_alarm_set_table_macros.svh
// assertion macros for the active alarm set table checker
`ifndef ACTIVE_ALARM_SET_TABLE_MACROS_SVH
`define ACTIVE_ALARM_SET_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define AAST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define AAST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/aast_pkg.sv
// package: sizes, request codes and item types of the active alarm set table
`default_nettype none

package aast_pkg;

  localparam int TABLE_DEPTH      = 32;
  localparam int WORDS_PER_BITMAP = 16;
  localparam int BITS_PER_WORD    = 16;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int WI_W  = (WORDS_PER_BITMAP > 1) ? $clog2(WORDS_PER_BITMAP) : 1;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_MASK = 2'd2,
    REQ_LIST = 2'd3
  } req_e;

  // input item
  typedef struct packed {
    req_e        req_type;
    logic [7:0]  alarm_number;
    logic        bitmap_select;
    logic [3:0]  word_index;
    logic [15:0] word_value;
  } req_t;

  // result item
  typedef struct packed {
    logic       item_valid;
    logic [7:0] visible_alarm;
    logic       last_item;
    logic       event_logged;
    logic       none_active;
    logic [5:0] stored_count;
  } rsp_t;

  // bitmap word write
  typedef struct packed {
    logic        we;
    logic        sel;
    logic [3:0]  idx;
    logic [15:0] val;
  } bmp_wr_t;

  // both bitmap bits of one alarm
  typedef struct packed {
    logic en;
    logic mask;
  } bmp_bits_t;

endpackage

`default_nettype wire

>>> src/active_alarm_set_table.sv
// active alarm set table: top level
//
//  channel   signals                 accepted when
//  request   start, busy, req_i      start high and busy low at a rising edge
//  result    valid_o, rsp_o          valid_o high, one cycle, cannot be held off
//
// every item scans the stored alarms once through the table ram, from accept
// until busy drops; the single ram read port, one entry per cycle, paces the scan
// a list item emits its visible alarms during the scan, the last one in the same
// cycle as busy drops; every other item gives its one result in that cycle
// reset empties the table and clears both bitmaps at once; no clearing pass
`default_nettype none

module active_alarm_set_table (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire aast_pkg::req_t req_i,
  output logic                valid_o,
  output aast_pkg::rsp_t      rsp_o
);
  import aast_pkg::*;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  bmp_wr_t          bmp_wr;
  logic [7:0]       bmp_alarm;
  bmp_bits_t        bmp_bits;

  // alarm number table
  aast_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // enable and display-mask bitmaps
  aast_bitmaps u_bitmaps (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (bmp_wr),
    .alarm_i (bmp_alarm),
    .bits_o  (bmp_bits)
  );

  // sequencer
  aast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .valid_o     (valid_o),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .bmp_wr_o    (bmp_wr),
    .bmp_alarm_o (bmp_alarm),
    .bmp_bits_i  (bmp_bits)
  );

endmodule

`default_nettype wire

>>> src/aast_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module aast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/aast_bitmaps.sv
// enable and display-mask bitmaps: word writes and a per-alarm bit lookup
`default_nettype none

module aast_bitmaps (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire aast_pkg::bmp_wr_t   wr_i,
  input  wire logic [7:0]          alarm_i,
  output aast_pkg::bmp_bits_t      bits_o
);
  import aast_pkg::*;

  logic [BITS_PER_WORD-1:0] en_q   [WORDS_PER_BITMAP];
  logic [BITS_PER_WORD-1:0] mask_q [WORDS_PER_BITMAP];

  logic            wr_ok;
  logic            rd_ok;
  logic [3:0]      rd_word;
  logic [WI_W-1:0] wr_sel;
  logic [WI_W-1:0] rd_sel;

  // out-of-range words are dropped on write and read as zero
  assign wr_ok   = int'(wr_i.idx) < WORDS_PER_BITMAP;
  assign wr_sel  = WI_W'(wr_i.idx);
  assign rd_word = alarm_i[7:4];
  assign rd_ok   = int'(rd_word) < WORDS_PER_BITMAP;
  assign rd_sel  = WI_W'(rd_word);

  // word write, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WORDS_PER_BITMAP; w++) begin
        en_q[w]   <= '0;
        mask_q[w] <= '0;
      end
    end else if (wr_i.we && wr_ok) begin
      if (wr_i.sel) begin
        mask_q[wr_sel] <= wr_i.val;
      end else begin
        en_q[wr_sel] <= wr_i.val;
      end
    end
  end

  // bit lookup for one alarm
  always_comb begin
    bits_o.en   = 1'b0;
    bits_o.mask = 1'b0;
    if (rd_ok) begin
      bits_o.en   = en_q[rd_sel][alarm_i[3:0]];
      bits_o.mask = mask_q[rd_sel][alarm_i[3:0]];
    end
  end

endmodule

`default_nettype wire

>>> src/aast_ctrl.sv
// sequencer: scans the alarm table once per item, shifts on delete, emits results
`default_nettype none

module aast_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire aast_pkg::req_t       req_i,
  output logic                      valid_o,
  output aast_pkg::rsp_t            rsp_o,
  // table ram
  output logic                      ram_we_o,
  output logic [aast_pkg::IDX_W-1:0] ram_waddr_o,
  output logic [7:0]                ram_wdata_o,
  output logic                      ram_re_o,
  output logic [aast_pkg::IDX_W-1:0] ram_raddr_o,
  input  wire logic [7:0]           ram_rdata_i,
  // bitmaps
  output aast_pkg::bmp_wr_t         bmp_wr_o,
  output logic [7:0]                bmp_alarm_o,
  input  wire aast_pkg::bmp_bits_t  bmp_bits_i
);
  import aast_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             rvld_q, rvld_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic             found_q, found_d;
  logic             hit_q, hit_d;
  logic             allen_q, allen_d;
  logic             pend_vld_q, pend_vld_d;
  logic [7:0]       pend_q, pend_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             flag_q, flag_d;
  logic             valid_q, valid_d;
  rsp_t             rsp_q, rsp_d;

  logic             match;
  logic             room;
  logic             allen_nx;
  logic [CNT_W-1:0] cnt_nx;
  logic             ev;

  assign busy        = state_q != ST_IDLE;
  assign valid_o     = valid_q;
  assign rsp_o       = rsp_q;
  assign match       = ram_rdata_i == req_q.alarm_number;
  assign room        = count_q < CNT_W'(TABLE_DEPTH);
  assign bmp_alarm_o = (state_q == ST_FIN) ? req_q.alarm_number : ram_rdata_i;
  assign ram_raddr_o = k_q[IDX_W-1:0];
  assign ram_re_o    = (state_q == ST_SCAN) && (k_q < count_q);

  // next-state and datapath
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    k_d        = k_q;
    rvld_d     = rvld_q;
    ridx_d     = ridx_q;
    found_d    = found_q;
    hit_d      = hit_q;
    allen_d    = allen_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    count_d    = count_q;
    flag_d     = flag_q;
    valid_d    = 1'b0;
    rsp_d      = rsp_q;
    allen_nx   = allen_q;
    cnt_nx     = count_q;
    ev         = 1'b0;

    ram_we_o    = 1'b0;
    ram_waddr_o = ridx_q - IDX_W'(1);
    ram_wdata_o = ram_rdata_i;

    bmp_wr_o.we  = 1'b0;
    bmp_wr_o.sel = req_i.bitmap_select;
    bmp_wr_o.idx = req_i.word_index;
    bmp_wr_o.val = req_i.word_value;

    case (state_q)
      // take an item; a mask write lands before the scan
      ST_IDLE: begin
        if (start) begin
          req_d       = req_i;
          k_d         = '0;
          rvld_d      = 1'b0;
          found_d     = 1'b0;
          hit_d       = 1'b0;
          allen_d     = 1'b1;
          pend_vld_d  = 1'b0;
          bmp_wr_o.we = req_i.req_type == REQ_MASK;
          state_d     = ST_SCAN;
        end
      end

      // one table entry per cycle: issue read, then act on the returned entry
      ST_SCAN: begin
        if (k_q < count_q) begin
          k_d    = k_q + CNT_W'(1);
          rvld_d = 1'b1;
          ridx_d = k_q[IDX_W-1:0];
        end else begin
          rvld_d = 1'b0;
          if (!rvld_q) begin
            state_d = ST_FIN;
          end
        end

        if (rvld_q) begin
          case (req_q.req_type)
            REQ_ADD: begin
              found_d = found_q | match;
              allen_d = allen_q & bmp_bits_i.en;
            end
            REQ_DEL: begin
              // entries after the first match move down one slot
              if (hit_q) begin
                ram_we_o = 1'b1;
              end
              if (hit_q || !match) begin
                allen_d = allen_q & bmp_bits_i.en;
              end else begin
                hit_d = 1'b1;
              end
            end
            REQ_MASK: begin
              allen_d = allen_q & bmp_bits_i.en;
            end
            REQ_LIST: begin
              // hold one visible entry back so the last can be marked
              if (!bmp_bits_i.mask) begin
                if (pend_vld_q) begin
                  valid_d             = 1'b1;
                  rsp_d.item_valid    = 1'b1;
                  rsp_d.visible_alarm = pend_q;
                  rsp_d.last_item     = 1'b0;
                  rsp_d.event_logged  = 1'b0;
                  rsp_d.none_active   = flag_q;
                  rsp_d.stored_count  = 6'(count_q);
                end
                pend_d     = ram_rdata_i;
                pend_vld_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // commit count and flag, append on add, emit the closing item
      ST_FIN: begin
        case (req_q.req_type)
          REQ_ADD: begin
            if (!found_q && room) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = count_q[IDX_W-1:0];
              ram_wdata_o = req_q.alarm_number;
              cnt_nx      = count_q + CNT_W'(1);
              ev          = 1'b1;
              allen_nx    = allen_q & bmp_bits_i.en;
            end
          end
          REQ_DEL: begin
            if (hit_q) begin
              cnt_nx = count_q - CNT_W'(1);
            end
          end
          REQ_LIST: begin
            allen_nx = flag_q;
          end
          default: begin
          end
        endcase

        flag_d  = allen_nx;
        count_d = cnt_nx;
        valid_d = 1'b1;
        if (req_q.req_type == REQ_LIST && pend_vld_q) begin
          rsp_d.item_valid    = 1'b1;
          rsp_d.visible_alarm = pend_q;
        end else begin
          rsp_d.item_valid    = 1'b0;
          rsp_d.visible_alarm = '0;
        end
        rsp_d.last_item    = 1'b1;
        rsp_d.event_logged = ev;
        rsp_d.none_active  = allen_nx;
        rsp_d.stored_count = 6'(cnt_nx);
        state_d            = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rvld_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      count_q    <= '0;
      flag_q     <= 1'b1;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rvld_q     <= rvld_d;
      pend_vld_q <= pend_vld_d;
      count_q    <= count_d;
      flag_q     <= flag_d;
      valid_q    <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    k_q     <= k_d;
    ridx_q  <= ridx_d;
    found_q <= found_d;
    hit_q   <= hit_d;
    allen_q <= allen_d;
    pend_q  <= pend_d;
    rsp_q   <= rsp_d;
  end

endmodule

`default_nettype wire

>>> src/aast_checker.sv
// port checker for the active alarm set table, bound to the top level
`default_nettype none

`include "active_alarm_set_table_macros.svh"

module aast_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           valid_o,
  input wire aast_pkg::rsp_t rsp_o
);
  import aast_pkg::*;

  // an accepted item keeps the block busy
  `AAST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

  // a result without an alarm always closes the item
  `AAST_ASSERT_NOW(a_empty_last, valid_o && !rsp_o.item_valid, rsp_o.last_item, "empty result not last")

  // more results follow a non-last one, so the block stays busy
  `AAST_ASSERT_NEXT(a_more_busy, valid_o && !rsp_o.last_item, busy, "block idle before last item")

  // the closing result frees the block
  `AAST_ASSERT_NOW(a_last_idle, valid_o && rsp_o.last_item, !busy, "still busy on last item")

  // count never passes the table depth
  `AAST_ASSERT_NOW(a_count_max, valid_o, int'(rsp_o.stored_count) <= TABLE_DEPTH, "count too large")

endmodule

bind active_alarm_set_table aast_checker u_aast_checker (.*);

`default_nettype wire

>>> tb/active_alarm_set_table_test.sv
// testbench for the active alarm set table: directed and random requests, scoreboard check
module active_alarm_set_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aast_pkg::*;

  // tracks the alarm set and both bitmaps, queues the results each item must give
  class alarm_table_scoreboard;
    logic [7:0]  alarms [TABLE_DEPTH];
    int unsigned alarm_count;
    logic [15:0] enable_words [WORDS_PER_BITMAP];
    logic [15:0] mask_words [WORDS_PER_BITMAP];
    rsp_t        expected_q [$];
    int unsigned mismatches;

    function new();
      alarm_count = 0;
      mismatches  = 0;
      foreach (enable_words[w]) begin
        enable_words[w] = '0;
        mask_words[w]   = '0;
      end
    endfunction

    // one bit of either bitmap; alarms past the last word read as zero
    function bit map_bit(bit from_mask, logic [7:0] num);
      int unsigned word;
      word = num / BITS_PER_WORD;
      if (word >= WORDS_PER_BITMAP) return 1'b0;
      if (from_mask) return mask_words[word][num % BITS_PER_WORD];
      return enable_words[word][num % BITS_PER_WORD];
    endfunction

    // every stored alarm enabled, true for an empty set
    function bit all_enabled();
      for (int i = 0; i < alarm_count; i++) begin
        if (!map_bit(1'b0, alarms[i])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void push_result(bit valid, logic [7:0] num, bit last, bit ev);
      rsp_t r;
      r.item_valid    = valid;
      r.visible_alarm = num;
      r.last_item     = last;
      r.event_logged  = ev;
      r.none_active   = all_enabled();
      r.stored_count  = 6'(alarm_count);
      expected_q.push_back(r);
    endfunction

    // apply an accepted item to the state and queue its results
    function void note_request(req_t r);
      bit         found;
      bit         ev;
      logic [7:0] shown [$];
      found = 1'b0;
      ev    = 1'b0;
      case (r.req_type)
        REQ_ADD: begin
          for (int i = 0; i < alarm_count; i++) begin
            if (alarms[i] == r.alarm_number) found = 1'b1;
          end
          if (!found && alarm_count < TABLE_DEPTH) begin
            alarms[alarm_count] = r.alarm_number;
            alarm_count++;
            ev = 1'b1;
          end
        end
        REQ_DEL: begin
          for (int i = 0; i < alarm_count; i++) begin
            if (alarms[i] == r.alarm_number) begin
              for (int j = i; j + 1 < alarm_count; j++) alarms[j] = alarms[j + 1];
              alarm_count--;
              break;
            end
          end
        end
        REQ_MASK: begin
          if (r.word_index < WORDS_PER_BITMAP) begin
            if (r.bitmap_select) mask_words[r.word_index] = r.word_value;
            else enable_words[r.word_index] = r.word_value;
          end
        end
        default: begin
          for (int i = 0; i < alarm_count; i++) begin
            if (!map_bit(1'b1, alarms[i])) shown.push_back(alarms[i]);
          end
          foreach (shown[k]) push_result(1'b1, shown[k], k + 1 == shown.size(), 1'b0);
          if (shown.size() > 0) return;
        end
      endcase
      push_result(1'b0, 8'd0, 1'b1, ev);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(rsp_t got);
      rsp_t want;
      bit   bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected result: valid %0b alarm %0d last %0b ev %0b none %0b cnt %0d",
                   $realtime, got.item_valid, got.visible_alarm, got.last_item,
                   got.event_logged, got.none_active, got.stored_count);
        return;
      end
      want = expected_q.pop_front();
      bad = (got.item_valid !== want.item_valid) || (got.visible_alarm !== want.visible_alarm) ||
            (got.last_item !== want.last_item) || (got.event_logged !== want.event_logged) ||
            (got.none_active !== want.none_active) || (got.stored_count !== want.stored_count);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t mismatch expected: valid %0b alarm %0d last %0b ev %0b none %0b cnt %0d",
                   $realtime, want.item_valid, want.visible_alarm, want.last_item,
                   want.event_logged, want.none_active, want.stored_count);
          $display("%0t mismatch actual:   valid %0b alarm %0d last %0b ev %0b none %0b cnt %0d",
                   $realtime, got.item_valid, got.visible_alarm, got.last_item,
                   got.event_logged, got.none_active, got.stored_count);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic valid_o;
  rsp_t rsp_o;

  alarm_table_scoreboard sb;
  int unsigned idle_pct;

  active_alarm_set_table uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // accepted items feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_request(req_i);
  end

  // every result strobe is checked
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(rsp_o);
  end

  // present one item, with an occasional random gap first, and hold until accepted
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off the sender until every queued result has arrived
  task automatic wait_for_drain();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (sb.pending() != 0 && guard < 5000);
  endtask

  function automatic req_t make_request(req_e op, logic [7:0] num, logic sel,
                                        logic [3:0] idx, logic [15:0] val);
    req_t r;
    r.req_type      = op;
    r.alarm_number  = num;
    r.bitmap_select = sel;
    r.word_index    = idx;
    r.word_value    = val;
    return r;
  endfunction

  // random item; alarm numbers lean on a pool larger than the table so it fills and repeats
  function automatic req_t random_request(int unsigned add_w, int unsigned del_w,
                                          int unsigned mask_w);
    req_t        r;
    int unsigned roll;
    r    = req_t'(31'($urandom));
    roll = $urandom_range(99);
    if (roll < add_w) r.req_type = REQ_ADD;
    else if (roll < add_w + del_w) r.req_type = REQ_DEL;
    else if (roll < add_w + del_w + mask_w) r.req_type = REQ_MASK;
    else r.req_type = REQ_LIST;
    roll = $urandom_range(99);
    if (roll < 55) r.alarm_number = 8'($urandom_range(0, 47) * 37);
    else if (roll < 80 && r.req_type == REQ_DEL && sb.alarm_count > 0)
      r.alarm_number = sb.alarms[$urandom_range(0, sb.alarm_count - 1)];
    roll = $urandom_range(99);
    if (roll < 35) r.word_value = 16'hffff;
    else if (roll < 50) r.word_value = 16'h0000;
    return r;
  endfunction

  // stimulus
  initial begin
    req_t        directed_q [$];
    int unsigned add_w;
    int unsigned del_w;
    int unsigned mask_w;
    rst_ni   = 1'b0;
    start    = 1'b0;
    req_i    = '0;
    idle_pct = 12;
    sb       = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, duplicate add, extreme numbers and words, hidden and absent cases
    directed_q.push_back(make_request(REQ_LIST, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_DEL, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_ADD, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_ADD, 8'd255, 1'b1, 4'd15, 16'hffff));
    directed_q.push_back(make_request(REQ_ADD, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_LIST, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_MASK, 8'd0, 1'b0, 4'd0, 16'h0001));
    directed_q.push_back(make_request(REQ_MASK, 8'd0, 1'b0, 4'd15, 16'h8000));
    directed_q.push_back(make_request(REQ_LIST, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_MASK, 8'd0, 1'b1, 4'd15, 16'hffff));
    directed_q.push_back(make_request(REQ_LIST, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_MASK, 8'd0, 1'b1, 4'd0, 16'hffff));
    directed_q.push_back(make_request(REQ_LIST, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_DEL, 8'd7, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_ADD, 8'd128, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_DEL, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_DEL, 8'd255, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_DEL, 8'd128, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_MASK, 8'd0, 1'b1, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_MASK, 8'd0, 1'b1, 4'd15, 16'h0000));
    directed_q.push_back(make_request(REQ_MASK, 8'd0, 1'b0, 4'd0, 16'h0000));
    directed_q.push_back(make_request(REQ_MASK, 8'd0, 1'b0, 4'd15, 16'h0000));
    foreach (directed_q[k]) send_request(directed_q[k]);
    wait_for_drain();

    // random blocks: fill first, then alternate draining and mixed traffic
    for (int blk = 0; blk < 10; blk++) begin
      if (blk == 0) begin
        add_w = 75; del_w = 5; mask_w = 10;
      end else if (blk % 2 == 1) begin
        add_w = 20; del_w = 50; mask_w = 15;
      end else begin
        add_w = 45; del_w = 20; mask_w = 15;
      end
      // long stretch with back-to-back items
      if (blk == 3) idle_pct = 0;
      if (blk == 6) idle_pct = 12;
      for (int n = 0; n < 50; n++) send_request(random_request(add_w, del_w, mask_w));
      if ($urandom_range(2) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (40) @(posedge clk_i);
    if (sb.pending() != 0)
      $display("%0t %0d expected results never arrived", $realtime, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/aast_pkg.sv
src/aast_ram.sv
src/aast_bitmaps.sv
src/aast_ctrl.sv
src/active_alarm_set_table.sv
src/aast_checker.sv
tb/active_alarm_set_table_test.sv
